[sv/stq_pkg.sv]
package stq_pkg;

	// Operation codes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_TICK   = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;
	localparam logic [1:0] MODE_POP    = 2'd3;

	// Result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_EXPIRED  = 3'd4;
	localparam logic [2:0] ST_NONE     = 3'd5;
	localparam logic [2:0] ST_ZERO     = 3'd6;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  thread_id;
		logic [7:0]  semaphore_id;
		logic [15:0] timeout;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] out_thread;
		logic [7:0] out_semaphore;
		logic [4:0] entry_count;
		logic       last;
	} rsp_t;

endpackage

[sv/sorted_timeout_queue.sv]
// Insert and remove scan the list from the head, reading and checking each entry; an insert
// then shifts the later entries up one slot and writes its own, a remove shifts them down. Pop
// takes the head and tick takes the expired entries from the head. A stalled receiver holds
// the results back. One transaction at a time: the next request is taken the cycle after the
// final result of the last one. Reset (arst_n low) empties the queue and clears the tick
// counter; RAM is left as is.
module sorted_timeout_queue #(
	parameter int CAPACITY  = 16,
	parameter int ID_BITS   = 8,
	parameter int TIME_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  stq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output stq_pkg::rsp_t rsp
);

	import stq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	// Entries hold an absolute deadline; remaining time is deadline minus the
	// tick counter, so a tick never has to touch the stored entries.
	typedef struct packed {
		logic [ID_BITS-1:0]   thread;
		logic [ID_BITS-1:0]   sema;
		logic [TIME_BITS-1:0] deadline;
	} entry_t;

	localparam int EW = $bits(entry_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CK,
		S_INS,
		S_SHU_RD,
		S_SHU_WR,
		S_INS_WR,
		S_SHD_RD,
		S_SHD_WR,
		S_POP_RD,
		S_POP_CK,
		S_T_RD,
		S_T_CK,
		S_RESP
	} state_t;

	state_t               state_q;
	logic [1:0]           mode_q;
	logic [ID_BITS-1:0]   thread_q;
	logic [ID_BITS-1:0]   sema_q;
	logic [TIME_BITS-1:0] time_q;
	logic [TIME_BITS-1:0] now_q;
	logic [IW-1:0]        head_q;
	logic [CW-1:0]        occ_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        pos_q;
	logic                 pos_set_q;
	logic                 found_q;
	logic                 pend_q;
	logic [2:0]           status_q;
	logic [ID_BITS-1:0]   ent_thread_q;
	logic [ID_BITS-1:0]   ent_sema_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic [CW-1:0]        rd_pos;
	logic [CW-1:0]        wr_pos;
	logic [IW-1:0]        rd_addr;
	logic [IW-1:0]        wr_addr;
	logic                 wr_en;
	entry_t               wr_data;
	entry_t               rd_data;
	logic [EW-1:0]        rd_raw;
	logic [TIME_BITS-1:0] rd_rem;
	logic                 rd_match;
	logic                 rd_expired;
	logic                 can_emit;
	logic                 rsp_load;
	logic                 req_acc;

	// Map a list position to its slot in the circular buffer.
	function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] p);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(p);
		if (s >= (CW+1)'(CAPACITY)) begin
			s = s - (CW+1)'(CAPACITY);
		end
		return s[IW-1:0];
	endfunction

	function automatic logic [ID_BITS-1:0] id_in(input logic [7:0] x);
		logic [ID_BITS+7:0] t;
		t = {{ID_BITS{1'b0}}, x};
		return t[ID_BITS-1:0];
	endfunction

	function automatic logic [7:0] id_out(input logic [ID_BITS-1:0] x);
		logic [ID_BITS+7:0] t;
		t = {8'b0, x};
		return t[7:0];
	endfunction

	function automatic logic [TIME_BITS-1:0] time_in(input logic [15:0] x);
		logic [TIME_BITS+15:0] t;
		t = {{TIME_BITS{1'b0}}, x};
		return t[TIME_BITS-1:0];
	endfunction

	function automatic logic [4:0] cnt_out(input logic [CW-1:0] x);
		logic [CW+4:0] t;
		t = {5'b0, x};
		return t[4:0];
	endfunction

	stq_ram #(
		.WIDTH (EW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	assign rd_data    = rd_raw;
	assign rd_rem     = rd_data.deadline - now_q;
	assign rd_match   = (rd_data.thread == thread_q);
	assign rd_expired = (rd_data.deadline == now_q);
	assign can_emit   = !rsp_valid_q || !rsp_stall;
	// a new result enters the output register this cycle
	assign rsp_load   = can_emit && ((state_q == S_RESP) ||
		((state_q == S_T_CK) && rd_expired && pend_q));
	assign req_stall  = (state_q != S_IDLE);
	assign req_acc    = req_valid && !req_stall;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;
	assign rd_addr    = phys(head_q, rd_pos);
	assign wr_addr    = phys(head_q, wr_pos);

	// RAM port control: shift up reads the slot below and writes it one up,
	// shift down reads the slot above and writes it one down.
	always_comb begin
		rd_pos  = idx_q;
		wr_pos  = idx_q;
		wr_en   = 1'b0;
		wr_data = rd_data;
		case (state_q)
			S_SHU_RD: begin
				rd_pos = idx_q - 1'b1;
			end
			S_SHU_WR: begin
				rd_pos = idx_q - 1'b1;
				wr_en  = 1'b1;
			end
			S_INS_WR: begin
				wr_en   = 1'b1;
				wr_pos  = pos_q;
				wr_data = '{thread: thread_q, sema: sema_q, deadline: now_q + time_q};
			end
			S_SHD_RD: begin
				rd_pos = idx_q + 1'b1;
			end
			S_SHD_WR: begin
				rd_pos = idx_q + 1'b1;
				wr_en  = 1'b1;
			end
			S_POP_RD, S_POP_CK, S_T_RD, S_T_CK: begin
				rd_pos = '0;
			end
			default: begin
				rd_pos = idx_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= MODE_INSERT;
			thread_q     <= '0;
			sema_q       <= '0;
			time_q       <= '0;
			now_q        <= '0;
			head_q       <= '0;
			occ_q        <= '0;
			idx_q        <= '0;
			pos_q        <= '0;
			pos_set_q    <= 1'b0;
			found_q      <= 1'b0;
			pend_q       <= 1'b0;
			status_q     <= ST_OK;
			ent_thread_q <= '0;
			ent_sema_q   <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			// drop the result once the receiver takes it, unless a new one replaces it
			if (rsp_valid_q && !rsp_stall && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						mode_q       <= req.mode;
						thread_q     <= id_in(req.thread_id);
						sema_q       <= id_in(req.semaphore_id);
						time_q       <= time_in(req.timeout);
						idx_q        <= '0;
						pos_q        <= occ_q;
						pos_set_q    <= 1'b0;
						found_q      <= 1'b0;
						pend_q       <= 1'b0;
						ent_thread_q <= '0;
						ent_sema_q   <= '0;
						case (req.mode)
							MODE_INSERT: begin
								state_q <= (occ_q == '0) ? S_INS : S_SCAN_RD;
							end
							MODE_REMOVE: begin
								if (occ_q == '0) begin
									status_q <= ST_NOTFOUND;
									state_q  <= S_RESP;
								end else begin
									state_q <= S_SCAN_RD;
								end
							end
							MODE_TICK: begin
								now_q <= now_q + 1'b1;
								if (occ_q == '0) begin
									status_q <= ST_NONE;
									state_q  <= S_RESP;
								end else begin
									state_q <= S_T_RD;
								end
							end
							default: begin
								if (occ_q == '0) begin
									status_q <= ST_NOTFOUND;
									state_q  <= S_RESP;
								end else begin
									state_q <= S_POP_RD;
								end
							end
						endcase
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CK;
				end
				S_SCAN_CK: begin
					// first entry with more time left marks the insert point
					if (!pos_set_q && rd_rem > time_q) begin
						pos_q     <= idx_q;
						pos_set_q <= 1'b1;
					end
					if (rd_match) begin
						found_q <= 1'b1;
						if (mode_q == MODE_REMOVE) begin
							ent_thread_q <= rd_data.thread;
							ent_sema_q   <= rd_data.sema;
							if (idx_q + 1'b1 == occ_q) begin
								occ_q    <= occ_q - 1'b1;
								status_q <= ST_OK;
								state_q  <= S_RESP;
							end else begin
								state_q <= S_SHD_RD;
							end
						end else begin
							state_q <= S_INS;
						end
					end else if (idx_q + 1'b1 == occ_q) begin
						if (mode_q == MODE_REMOVE) begin
							status_q <= ST_NOTFOUND;
							state_q  <= S_RESP;
						end else begin
							state_q <= S_INS;
						end
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_INS: begin
					// duplicate beats full, full beats zero timeout
					if (found_q) begin
						status_q <= ST_DUP;
						state_q  <= S_RESP;
					end else if (occ_q >= CW'(CAPACITY)) begin
						status_q <= ST_FULL;
						state_q  <= S_RESP;
					end else if (time_q == '0) begin
						status_q <= ST_ZERO;
						state_q  <= S_RESP;
					end else begin
						idx_q   <= occ_q;
						state_q <= (occ_q == pos_q) ? S_INS_WR : S_SHU_RD;
					end
				end
				S_SHU_RD: begin
					state_q <= S_SHU_WR;
				end
				S_SHU_WR: begin
					idx_q   <= idx_q - 1'b1;
					state_q <= (idx_q - 1'b1 == pos_q) ? S_INS_WR : S_SHU_RD;
				end
				S_INS_WR: begin
					occ_q    <= occ_q + 1'b1;
					status_q <= ST_OK;
					state_q  <= S_RESP;
				end
				S_SHD_RD: begin
					state_q <= S_SHD_WR;
				end
				S_SHD_WR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q + 2'd2 == occ_q) begin
						occ_q    <= occ_q - 1'b1;
						status_q <= ST_OK;
						state_q  <= S_RESP;
					end else begin
						state_q <= S_SHD_RD;
					end
				end
				S_POP_RD: begin
					state_q <= S_POP_CK;
				end
				S_POP_CK: begin
					ent_thread_q <= rd_data.thread;
					ent_sema_q   <= rd_data.sema;
					head_q       <= phys(head_q, CW'(1));
					occ_q        <= occ_q - 1'b1;
					status_q     <= ST_OK;
					state_q      <= S_RESP;
				end
				S_T_RD: begin
					state_q <= S_T_CK;
				end
				S_T_CK: begin
					// hold one expired entry back until we know whether it is the last
					if (rd_expired) begin
						if (!pend_q || can_emit) begin
							if (pend_q) begin
								rsp_valid_q <= 1'b1;
								rsp_q       <= '{status: ST_EXPIRED,
									out_thread: id_out(ent_thread_q),
									out_semaphore: id_out(ent_sema_q),
									entry_count: cnt_out(occ_q), last: 1'b0};
							end
							pend_q       <= 1'b1;
							ent_thread_q <= rd_data.thread;
							ent_sema_q   <= rd_data.sema;
							head_q       <= phys(head_q, CW'(1));
							occ_q        <= occ_q - 1'b1;
							if (occ_q == CW'(1)) begin
								status_q <= ST_EXPIRED;
								state_q  <= S_RESP;
							end else begin
								state_q <= S_T_RD;
							end
						end
					end else begin
						status_q <= pend_q ? ST_EXPIRED : ST_NONE;
						state_q  <= S_RESP;
					end
				end
				S_RESP: begin
					if (can_emit) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= '{status: status_q,
							out_thread: id_out(ent_thread_q),
							out_semaphore: id_out(ent_sema_q),
							entry_count: cnt_out(occ_q), last: 1'b1};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	ap_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	ap_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != $past(occ_q)) |->
		((occ_q == $past(occ_q) + 1'b1) || (occ_q + 1'b1 == $past(occ_q))))
		else $error("entry count moved by more than one");

	ap_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_WR) |-> (occ_q < CW'(CAPACITY)))
		else $error("insert write with a full table");

	ap_tick_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_T_CK) |-> (occ_q != '0))
		else $error("expiry check on an empty list");

	ap_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.last) |-> (rsp_q.status == ST_EXPIRED))
		else $error("non-final result that is not an expiry");

endmodule

[sv/stq_ram.sv]
module stq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[dv/tb_sorted_timeout_queue.sv]
`timescale 1ns / 100ps

module tb_sorted_timeout_queue;
	import stq_pkg::*;

	localparam int QUEUE_DEPTH    = 16;
	localparam int SETTLE_CYCLES  = 100;
	// Receiver hold, set at the start of the first phase so the block backs up.
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 62;
	localparam int SEND_IDLE[4]   = '{0, 48, 0, 17};
	localparam int RECV_STALL[4]  = '{0, 0, 48, 17};

	typedef struct packed {
		logic [7:0]  thread;
		logic [7:0]  sem;
		logic [15:0] ticks;
	} waiter_t;

	// Timer list scoreboard: mirrors the sorted waiter list and books the
	// results each accepted request must produce.
	class timer_list_book;
		waiter_t waiters[$];
		rsp_t    due_results[$];
		int      mismatches;

		function int find_thread(logic [7:0] id);
			foreach (waiters[i])
				if (waiters[i].thread == id)
					return i;
			return -1;
		endfunction

		function void book_result(logic [2:0] status, logic [7:0] thread,
				logic [7:0] sem, logic last);
			rsp_t r;
			r.status        = status;
			r.out_thread    = thread;
			r.out_semaphore = sem;
			r.entry_count   = 5'(waiters.size());
			r.last          = last;
			due_results.push_back(r);
		endfunction

		function void note_request(req_t r);
			waiter_t w;
			int      pos;
			case (r.mode)
				MODE_INSERT: begin
					if (find_thread(r.thread_id) >= 0) begin
						book_result(ST_DUP, 8'd0, 8'd0, 1'b1);
					end else if (waiters.size() >= QUEUE_DEPTH) begin
						book_result(ST_FULL, 8'd0, 8'd0, 1'b1);
					end else if (r.timeout == 16'd0) begin
						book_result(ST_ZERO, 8'd0, 8'd0, 1'b1);
					end else begin
						// Place after every waiter due at or before the new one.
						pos = 0;
						while (pos < waiters.size() && waiters[pos].ticks <= r.timeout)
							pos++;
						w.thread = r.thread_id;
						w.sem    = r.semaphore_id;
						w.ticks  = r.timeout;
						waiters.insert(pos, w);
						book_result(ST_OK, 8'd0, 8'd0, 1'b1);
					end
				end
				MODE_TICK: begin
					foreach (waiters[i])
						waiters[i].ticks = waiters[i].ticks - 16'd1;
					// Expired waiters form a prefix of the sorted list.
					if (waiters.size() == 0 || waiters[0].ticks != 16'd0) begin
						book_result(ST_NONE, 8'd0, 8'd0, 1'b1);
					end else begin
						while (waiters.size() > 0 && waiters[0].ticks == 16'd0) begin
							w = waiters.pop_front();
							book_result(ST_EXPIRED, w.thread, w.sem,
								waiters.size() == 0 || waiters[0].ticks != 16'd0);
						end
					end
				end
				MODE_REMOVE: begin
					pos = find_thread(r.thread_id);
					if (pos < 0) begin
						book_result(ST_NOTFOUND, 8'd0, 8'd0, 1'b1);
					end else begin
						w = waiters[pos];
						waiters.delete(pos);
						book_result(ST_OK, w.thread, w.sem, 1'b1);
					end
				end
				default: begin
					if (waiters.size() == 0) begin
						book_result(ST_NOTFOUND, 8'd0, 8'd0, 1'b1);
					end else begin
						w = waiters.pop_front();
						book_result(ST_OK, w.thread, w.sem, 1'b1);
					end
				end
			endcase
		endfunction

		function void log_mismatch(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH %0t: %s", $realtime, what);
		endfunction

		function string show(rsp_t r);
			return $sformatf("status=%0d thread=%0d sem=%0d count=%0d last=%0b",
				r.status, r.out_thread, r.out_semaphore, r.entry_count, r.last);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (due_results.size() == 0) begin
				log_mismatch({"unexpected result ", show(got)});
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status || got.out_thread !== want.out_thread ||
					got.out_semaphore !== want.out_semaphore ||
					got.entry_count !== want.entry_count || got.last !== want.last)
				log_mismatch({"expected ", show(want), " actual ", show(got)});
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	timer_list_book book = new();

	int send_idle_pct;
	int recv_stall_pct;
	int rsp_hold_cycles;
	int quiet_cycles;
	bit req_taken;
	bit rsp_taken;

	sorted_timeout_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watch both channels at each edge: book every accepted request, check every
	// accepted result, and end the run if nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken = req_valid && req_stall === 1'b0;
			rsp_taken = rsp_valid === 1'b1 && !rsp_stall;
			if (req_taken)
				book.note_request(req);
			if (rsp_taken)
				book.check_result(rsp);
			if (req_taken || rsp_taken)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Receiver: stall at random; on request, hold off for a long stretch counted
	// here so the block backs up into its request channel.
	initial begin
		int span;
		forever begin
			@(posedge clk);
			if (rsp_hold_cycles != 0) begin
				span = rsp_hold_cycles;
				rsp_hold_cycles = 0;
				rsp_stall <= 1'b1;
				repeat (span) @(posedge clk);
			end
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Offer one transaction, with random idle cycles ahead of it, and hold it
	// until the block takes it.
	task automatic drive_request(req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall !== 1'b0);
	endtask

	task automatic send_op(logic [1:0] mode, logic [7:0] thread, logic [7:0] sem,
			logic [15:0] ticks);
		req_t item;
		item.mode         = mode;
		item.thread_id    = thread;
		item.semaphore_id = sem;
		item.timeout      = ticks;
		drive_request(item);
	endtask

	// Stop offering and wait until every booked result has come back.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (book.outstanding() != 0);
	endtask

	// Mostly short timeouts from a small id pool so that duplicates, removes
	// that hit and expiries are common; the rest spans the full field ranges.
	function automatic req_t random_request();
		req_t        r;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40)
			r.mode = MODE_INSERT;
		else if (pick < 70)
			r.mode = MODE_TICK;
		else if (pick < 85)
			r.mode = MODE_REMOVE;
		else
			r.mode = MODE_POP;
		r.thread_id    = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(23));
		r.semaphore_id = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 6)
			r.timeout = 16'd0;
		else if (pick < 14)
			r.timeout = 16'($urandom);
		else
			r.timeout = 16'($urandom_range(6, 1));
		return r;
	endfunction

	initial begin
		int sent;
		int base;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		rsp_hold_cycles = 0;
		quiet_cycles    = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty-list cases: pop, tick, remove of an absent id, zero timeout.
		send_op(MODE_POP, 8'd0, 8'd0, 16'd0);
		send_op(MODE_TICK, 8'd0, 8'd0, 16'd0);
		send_op(MODE_REMOVE, 8'd77, 8'd0, 16'd0);
		send_op(MODE_INSERT, 8'd3, 8'd9, 16'd0);
		// Fill the list: repeated timeouts check insertion order among equal times,
		// id and semaphore extremes sit at both ends.
		for (int k = 0; k < QUEUE_DEPTH; k++)
			send_op(MODE_INSERT, (k == QUEUE_DEPTH - 1) ? 8'd255 : 8'(k),
				(k == 0) ? 8'd255 : (k == QUEUE_DEPTH - 1) ? 8'd0 : 8'(k * 7),
				(k == QUEUE_DEPTH - 1) ? 16'hFFFF : 16'((k % 4) + 1));
		// Full list: duplicate wins over full, full wins over zero timeout.
		send_op(MODE_INSERT, 8'd0, 8'd1, 16'd5);
		send_op(MODE_INSERT, 8'd200, 8'd1, 16'd5);
		send_op(MODE_INSERT, 8'd201, 8'd1, 16'd0);
		// Expire several at once, then remove from the middle and pop the head.
		send_op(MODE_TICK, 8'd0, 8'd0, 16'd0);
		send_op(MODE_REMOVE, 8'd2, 8'd0, 16'd0);
		send_op(MODE_POP, 8'd0, 8'd0, 16'd0);

		for (int ph = 0; ph < 4; ph++) begin
			// Pause the sender until all results are back, then change idling.
			wait_drained();
			send_idle_pct  = SEND_IDLE[ph];
			recv_stall_pct = RECV_STALL[ph];
			if (ph == 0)
				rsp_hold_cycles = HOLD_CYCLES;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(24) == 0) begin
					// Burst of inserts to push the list to full.
					base = $urandom_range(200);
					for (int k = 0; k < 12; k++)
						send_op(MODE_INSERT, 8'(base + k), 8'($urandom),
							16'($urandom_range(8, 1)));
					sent += 12;
				end else begin
					drive_request(random_request());
					sent++;
				end
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (book.mismatches == 0 && book.outstanding() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
